/* rtl/core/rsfp_pkg.sv */
// ----------------------------------------------------------------------------
// rsfp_pkg
// Shared constants and record kinds for the RFID serial frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rsfp_pkg;

	localparam logic [7:0] HEADER_BYTE  = 8'hBB;
	localparam logic [7:0] TRAILER_BYTE = 8'h7E;

	typedef enum logic [2:0] {
		KIND_HEADER   = 3'd0,
		KIND_PAYLOAD  = 3'd1,
		KIND_GOOD     = 3'd2,
		KIND_BAD_TRLR = 3'd3,
		KIND_BAD_CSUM = 3'd4
	} record_kind_t;

endpackage

`default_nettype wire

/* rtl/core/rfid_serial_frame_parser_top.sv */
// ----------------------------------------------------------------------------
// rfid_serial_frame_parser_top
// Deframes 0xBB / type / command / length / payload / checksum / 0x7E packets.
// ----------------------------------------------------------------------------
// One received byte per word in; one record per word out. Takes a byte every
// cycle unless the output stalls; a byte goes through an input register and
// a result register before its record shows. Header record after the
// low length byte, one record per payload byte, one end record (good, bad
// trailer, bad checksum) at the trailer position; other bytes give nothing.
`default_nettype none

module rfid_serial_frame_parser_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // rx_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,   // frame_type, frame_command, payload_length, data_byte
	output logic [2:0]       m_axis_tuser    // record_kind
);
	import rsfp_pkg::*;

	typedef enum logic [2:0] {
		PH_HUNT, PH_TYPE, PH_CMD, PH_LEN_HI, PH_LEN_LO, PH_PAYLOAD, PH_CHECKSUM, PH_TRAILER
	} phase_t;

	phase_t       phase_q, phase_d;
	logic [7:0]   sum_q, sum_d;
	logic [15:0]  left_q, left_d;
	logic [7:0]   len_hi_q, len_hi_d;
	logic [7:0]   len_lo_q, len_lo_d;
	logic [7:0]   type_q, type_d;
	logic [7:0]   cmd_q, cmd_d;
	logic [7:0]   csum_q, csum_d;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         valid_s2;
	record_kind_t kind_s2;
	logic [7:0]   type_s2, cmd_s2, data_s2;
	logic [15:0]  len_s2;

	logic         s2_free, step;
	logic         emit;
	record_kind_t kind;
	logic [7:0]   data;
	logic [15:0]  left_dec;

	assign s2_free       = !valid_s2 || m_axis_tready;
	assign step          = valid_s1 && s2_free;
	assign s_axis_tready = !valid_s1 || step;
	assign left_dec      = left_q - 16'd1;

	always_comb begin
		phase_d  = phase_q;
		sum_d    = sum_q;
		left_d   = left_q;
		len_hi_d = len_hi_q;
		len_lo_d = len_lo_q;
		type_d   = type_q;
		cmd_d    = cmd_q;
		csum_d   = csum_q;
		emit     = 1'b0;
		kind     = KIND_HEADER;
		data     = 8'd0;
		unique case (phase_q)
			PH_HUNT: begin
				if (byte_s1 == HEADER_BYTE) begin
					sum_d   = 8'd0;
					phase_d = PH_TYPE;
				end
			end
			PH_TYPE: begin
				type_d  = byte_s1;
				sum_d   = sum_q + byte_s1;
				phase_d = PH_CMD;
			end
			PH_CMD: begin
				cmd_d   = byte_s1;
				sum_d   = sum_q + byte_s1;
				phase_d = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				len_hi_d = byte_s1;
				sum_d    = sum_q + byte_s1;
				phase_d  = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				len_lo_d = byte_s1;
				sum_d    = sum_q + byte_s1;
				left_d   = {len_hi_q, byte_s1};
				emit     = 1'b1;
				kind     = KIND_HEADER;
				phase_d  = ({len_hi_q, byte_s1} == 16'd0) ? PH_CHECKSUM : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				sum_d  = sum_q + byte_s1;
				emit   = 1'b1;
				kind   = KIND_PAYLOAD;
				data   = byte_s1;
				left_d = left_dec;
				if (left_dec == 16'd0) begin
					phase_d = PH_CHECKSUM;
				end
			end
			PH_CHECKSUM: begin
				csum_d  = byte_s1;
				phase_d = PH_TRAILER;
			end
			PH_TRAILER: begin
				emit = 1'b1;
				priority if (byte_s1 != TRAILER_BYTE) begin
					kind = KIND_BAD_TRLR;
				end else if (sum_q != csum_q) begin
					kind = KIND_BAD_CSUM;
				end else begin
					kind = KIND_GOOD;
				end
				phase_d = PH_HUNT;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			phase_q  <= PH_HUNT;
			sum_q    <= 8'd0;
			left_q   <= 16'd0;
			len_hi_q <= 8'd0;
			len_lo_q <= 8'd0;
			type_q   <= 8'd0;
			cmd_q    <= 8'd0;
			csum_q   <= 8'd0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (step) begin
				phase_q  <= phase_d;
				sum_q    <= sum_d;
				left_q   <= left_d;
				len_hi_q <= len_hi_d;
				len_lo_q <= len_lo_d;
				type_q   <= type_d;
				cmd_q    <= cmd_d;
				csum_q   <= csum_d;
				valid_s2 <= emit;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
		if (step && emit) begin
			kind_s2 <= kind;
			type_s2 <= type_d;
			cmd_s2  <= cmd_d;
			len_s2  <= {len_hi_d, len_lo_d};
			data_s2 <= data;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {data_s2, len_s2, cmd_s2, type_s2};
	assign m_axis_tuser  = kind_s2;

endmodule

`default_nettype wire

/* rtl/core/rsfp_checker.sv */
// ----------------------------------------------------------------------------
// rsfp_checker
// Port-level checks on the RFID serial frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

module rsfp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [7:0]  s_axis_tdata,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [39:0] m_axis_tdata,
	input wire logic [2:0]  m_axis_tuser
);
	import rsfp_pkg::*;

	logic in_word;
	assign in_word = s_axis_tvalid && s_axis_tready;

	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid |-> !$isunknown(s_axis_tdata))
		else $error("input word carries unknown bits");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output word changed while stalled");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser <= KIND_BAD_CSUM)
		else $error("record kind out of range");

	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != KIND_PAYLOAD |-> m_axis_tdata[39:32] == 8'd0)
		else $error("data byte set on non-payload record");

	a_rise_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(in_word, 2))
		else $error("record without an input word two cycles earlier");

endmodule

bind rfid_serial_frame_parser_top rsfp_checker u_rsfp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
